>>> rtl/sstfp_pkg.sv
// Package for the shortest-seek-time-first request picker.
// Holds sizes, op and status codes, payload and cell types, and sector width helpers.
// Used by sstfp_cell and sstf_request_picker_core; depends on nothing.
`default_nettype none

package sstfp_pkg;

    // Queue size and stored sector width.
    localparam int QUEUE_DEPTH = 16;
    localparam int SECTOR_BITS = 48;
    localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Fixed widths of the channel fields.
    localparam int OP_BITS      = 2;
    localparam int FIELD_SECTOR = 48;
    localparam int TAG_BITS     = 8;
    localparam int STATUS_BITS  = 2;

    // Operation codes carried on the request channel.
    typedef enum logic [OP_BITS-1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_REMOVE   = 2'd2
    } op_e;

    // Status codes returned on the response channel.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_e;

    // Request payload.
    typedef struct packed {
        logic [OP_BITS-1:0]      op;
        logic [FIELD_SECTOR-1:0] sector;
        logic [TAG_BITS-1:0]     tag;
    } req_t;

    // Response payload.
    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        logic [FIELD_SECTOR-1:0] out_sector;
        logic [TAG_BITS-1:0]     out_tag;
    } rsp_t;

    // One queue entry as seen by the neighboring cell.
    typedef struct packed {
        logic                   valid;
        logic [TAG_BITS-1:0]    tag;
        logic [SECTOR_BITS-1:0] sector;
    } entry_t;

    // Running best candidate handed along the chain during a dispatch scan.
    typedef struct packed {
        logic                   valid;
        logic [SECTOR_BITS-1:0] seek_gap;
        logic [IDX_BITS-1:0]    idx;
        logic [SECTOR_BITS-1:0] sector;
        logic [TAG_BITS-1:0]    tag;
    } scan_t;

    // Per-cycle commands broadcast from the controller to every cell.
    typedef struct packed {
        logic load_dist;
        logic scan_en;
        logic add_en;
        logic tag_remove_en;
        logic disp_remove_en;
    } cell_ctrl_t;

    // Fit a channel sector to the stored sector width.
    function automatic logic [SECTOR_BITS-1:0] to_sector(input logic [FIELD_SECTOR-1:0] s);
        logic [63:0] w;
        w = 64'(s);
        return w[SECTOR_BITS-1:0];
    endfunction

    // Fit a stored sector to the channel sector width.
    function automatic logic [FIELD_SECTOR-1:0] from_sector(input logic [SECTOR_BITS-1:0] s);
        logic [63:0] w;
        w = 64'(s);
        return w[FIELD_SECTOR-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/sstfp_cell.sv
// One cell of the request queue chain: a stored request, its seek distance and
// one stage of the nearest-request scan.
// Depends on sstfp_pkg.
`default_nettype none

module sstfp_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sstfp_pkg::cell_ctrl_t             ctrl,
    input  logic [sstfp_pkg::IDX_BITS-1:0]    index,
    input  logic [sstfp_pkg::IDX_BITS-1:0]    pick_idx,
    input  logic [sstfp_pkg::SECTOR_BITS-1:0] new_sector,
    input  logic [sstfp_pkg::TAG_BITS-1:0]    new_tag,
    input  logic [sstfp_pkg::SECTOR_BITS-1:0] track_pos,
    input  logic                              prev_valid,
    input  sstfp_pkg::entry_t                 up,
    output sstfp_pkg::entry_t                 entry,
    input  logic                              seen_in,
    output logic                              seen_out,
    input  sstfp_pkg::scan_t                  scan_in,
    output sstfp_pkg::scan_t                  scan_out
);
    import sstfp_pkg::*;

    logic                   valid_reg, valid_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic [SECTOR_BITS-1:0] dist_reg, dist_next;
    scan_t                  scan_reg, scan_next;
    logic                   match;
    logic                   shift;
    logic                   take;

    assign entry = '{valid: valid_reg, tag: tag_reg, sector: sector_reg};

    // A tag match here or in any older cell marks this cell for the shift-down.
    assign match    = valid_reg && (tag_reg == new_tag);
    assign seen_out = seen_in || match;

    // The removed entry and every younger one take the contents of the next cell up.
    assign shift = (ctrl.tag_remove_en && seen_out)
                || (ctrl.disp_remove_en && (index >= pick_idx));

    // A new request lands in the first free cell.
    assign take = ctrl.add_en && !valid_reg && prev_valid;

    // Entry update.
    always_comb
    begin
        valid_next  = valid_reg;
        tag_next    = tag_reg;
        sector_next = sector_reg;
        if (take)
        begin
            valid_next  = 1'b1;
            tag_next    = new_tag;
            sector_next = new_sector;
        end
        else if (shift)
        begin
            valid_next  = up.valid;
            tag_next    = up.tag;
            sector_next = up.sector;
        end
    end

    // Absolute seek distance from the last dispatched position.
    always_comb
    begin
        dist_next = dist_reg;
        if (ctrl.load_dist)
        begin
            if (sector_reg >= track_pos)
                dist_next = sector_reg - track_pos;
            else
                dist_next = track_pos - sector_reg;
        end
    end

    // Scan stage: keep the older candidate unless this one is strictly closer.
    always_comb
    begin
        scan_next = scan_reg;
        if (ctrl.scan_en)
        begin
            if (valid_reg && (!scan_in.valid || (dist_reg < scan_in.seek_gap)))
                scan_next = '{valid: 1'b1, seek_gap: dist_reg, idx: index,
                              sector: sector_reg, tag: tag_reg};
            else
                scan_next = scan_in;
        end
    end

    assign scan_out = scan_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tag_reg    <= tag_next;
        sector_reg <= sector_next;
        dist_reg   <= dist_next;
        scan_reg   <= scan_next;
    end

endmodule

`default_nettype wire

>>> rtl/sstf_request_picker_core.sv
// Shortest-seek-time-first request picker: top level with controller and cell chain.
// Depends on sstfp_pkg and sstfp_cell.
//
// The block keeps up to QUEUE_DEPTH pending disk requests in a chain of cells,
// oldest in cell 0. An add or a remove-by-tag goes from S_IDLE to S_FINISH,
// where its response is registered once the output register is free. A
// dispatch passes through S_DIST, which loads every cell's seek distance, and
// S_SCAN, where the running nearest candidate moves one cell per cycle along the
// chain, so the scan over the chain sets the dispatch time. Equal distances
// resolve to the oldest request. One request is in work at a time; a new
// request is taken while the previous response still waits in the output register.
`default_nettype none

module sstf_request_picker_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  sstfp_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output sstfp_pkg::rsp_t rsp
);
    import sstfp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DIST   = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_BITS-1:0]    cnt_reg, cnt_next;
    logic [OP_BITS-1:0]     op_reg, op_next;
    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [SECTOR_BITS-1:0] track_pos_reg, track_pos_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_t                   rsp_reg, rsp_next;

    cell_ctrl_t             ctrl;
    entry_t                 ent [QUEUE_DEPTH];
    logic                   seen [QUEUE_DEPTH+1];
    scan_t                  scan [QUEUE_DEPTH+1];
    scan_t                  best;
    logic                   accept;
    logic                   commit;
    logic                   full;
    logic                   empty;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign commit    = (state_reg == S_FINISH) && (!rsp_valid_reg || rsp_ready);

    assign full  = ent[QUEUE_DEPTH-1].valid;
    assign empty = !ent[0].valid;
    assign best  = scan[QUEUE_DEPTH];

    // Commands to the cells.
    always_comb
    begin
        ctrl = '0;
        ctrl.load_dist      = (state_reg == S_DIST);
        ctrl.scan_en        = (state_reg == S_SCAN);
        ctrl.add_en         = commit && (op_reg == OP_ADD) && !full;
        ctrl.tag_remove_en  = commit && (op_reg == OP_REMOVE);
        ctrl.disp_remove_en = commit && (op_reg == OP_DISPATCH) && !empty && best.valid;
    end

    // Cell chain: entries shift down from above, tag matches and scan candidates move up.
    assign seen[0] = 1'b0;
    assign scan[0] = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t up_entry;
        logic   prev_valid;

        if (i == QUEUE_DEPTH - 1)
        begin : g_top
            assign up_entry = '0;
        end
        else
        begin : g_mid
            assign up_entry = ent[i+1];
        end

        if (i == 0)
        begin : g_first
            assign prev_valid = 1'b1;
        end
        else
        begin : g_rest
            assign prev_valid = ent[i-1].valid;
        end

        sstfp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .index      (IDX_BITS'(i)),
            .pick_idx   (best.idx),
            .new_sector (sector_reg),
            .new_tag    (tag_reg),
            .track_pos  (track_pos_reg),
            .prev_valid (prev_valid),
            .up         (up_entry),
            .entry      (ent[i]),
            .seen_in    (seen[i]),
            .seen_out   (seen[i+1]),
            .scan_in    (scan[i]),
            .scan_out   (scan[i+1])
        );
    end

    // Sequencer and response formation.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        op_next        = op_reg;
        sector_next    = sector_reg;
        tag_next       = tag_reg;
        track_pos_next = track_pos_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.op;
                    sector_next = to_sector(req.sector);
                    tag_next    = req.tag;
                    if (req.op == OP_DISPATCH)
                        state_next = S_DIST;
                    else
                        state_next = S_FINISH;
                end
            end
            S_DIST:
            begin
                cnt_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_BITS'(QUEUE_DEPTH - 1))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (commit)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: ST_OK, out_sector: '0, out_tag: '0};
                    case (op_reg)
                        OP_ADD:
                        begin
                            if (full)
                                rsp_next.status = ST_FULL;
                        end
                        OP_DISPATCH:
                        begin
                            if (empty || !best.valid)
                            begin
                                rsp_next.status = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_next.out_sector = from_sector(best.sector);
                                rsp_next.out_tag    = best.tag;
                                track_pos_next      = best.sector;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!seen[QUEUE_DEPTH])
                                rsp_next.status = ST_NOTFOUND;
                        end
                        default:
                        begin
                            rsp_next.status = ST_OK;
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            op_reg        <= '0;
            track_pos_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            track_pos_reg <= track_pos_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sector_reg <= sector_next;
        tag_reg    <= tag_next;
        rsp_reg    <= rsp_next;
    end

endmodule

`default_nettype wire
